[sv/twbf_pkg.sv]
package twbf_pkg;

   localparam int DEFAULT_BUFFER_DEPTH = 32;
   localparam int DEFAULT_ADDR_BITS    = 48;
   localparam int FIELD_ADDR_W         = 48;
   localparam int DATA_W               = 64;
   localparam int FILTER_W             = 32;
   localparam int KIND_W               = 3;
   localparam logic [4:0] HASH_MASK    = 5'h1F;

   typedef enum logic [1:0] {
      FUNC_START  = 2'd0,
      FUNC_STORE  = 2'd1,
      FUNC_LOAD   = 2'd2,
      FUNC_COMMIT = 2'd3
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACK       = 3'd0,
      KIND_LOAD      = 3'd1,
      KIND_WRITEBACK = 3'd2,
      KIND_EMPTY     = 3'd3,
      KIND_OVERFLOW  = 3'd4
   } kind_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic shift;
      logic write;
   } cell_ctrl_type;

   // Filter bit index from the low address bits: ((a>>2)^(a>>5)) & 0x1F.
   function automatic logic [4:0] filter_index(logic [9:0] a);
      return (a[6:2] ^ a[9:5]) & HASH_MASK;
   endfunction

endpackage

[sv/twbf_req_if.sv]
interface twbf_req_if
   import twbf_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [1:0]               func;
   logic [FIELD_ADDR_W-1:0]  addr;
   logic signed [DATA_W-1:0] value;
   logic signed [DATA_W-1:0] mem_value;

   modport source (output valid, func, addr, value, mem_value, input ready);
   modport sink   (input valid, func, addr, value, mem_value, output ready);
endinterface

[sv/twbf_rsp_if.sv]
interface twbf_rsp_if
   import twbf_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic [FIELD_ADDR_W-1:0]  out_addr;
   logic signed [DATA_W-1:0] out_value;
   logic                     forwarded;
   logic                     overflowed;
   logic                     last;

   modport source (output valid, kind, out_addr, out_value, forwarded, overflowed, last,
                   input ready);
   modport sink   (input valid, kind, out_addr, out_value, forwarded, overflowed, last,
                   output ready);
endinterface

[sv/twbf_cell.sv]
module twbf_cell
   import twbf_pkg::*;
#(
   parameter int ADDR_BITS = DEFAULT_ADDR_BITS
) (
   input  logic                 clock,
   input  cell_ctrl_type        ctrl,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_W-1:0]    wr_data,
   input  logic [ADDR_BITS-1:0] nbr_addr,
   input  logic [DATA_W-1:0]    nbr_data,
   input  logic [ADDR_BITS-1:0] key,
   output logic [ADDR_BITS-1:0] addr_ff,
   output logic [DATA_W-1:0]    data_ff,
   output logic                 match_ff
);

   logic [ADDR_BITS-1:0] addr_in;
   logic [DATA_W-1:0]    data_in;

   // During a commit the whole row moves one place toward the head for each word sent.
   always_comb begin
      addr_in = addr_ff;
      data_in = data_ff;
      if (ctrl.shift) begin
         addr_in = nbr_addr;
         data_in = nbr_data;
      end else if (ctrl.write) begin
         addr_in = wr_addr;
         data_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      data_ff  <= data_in;
      match_ff <= (addr_ff == key);
   end

endmodule

[sv/tx_write_buffer_bloom_forward_unit.sv]
// Start, store, filter-miss load and empty commit: result registered on accept.
// Filter-hit load: key registered on accept, then cell compare, then newest-match select.
// Commit of N entries: N words, one per cycle while the result side keeps up; the row of
// cells shifts toward the head once per word, and the next request is taken after the last.
// Simple items sustain one per cycle while the result side keeps up.
// Synchronous active-high reset empties the buffer and clears the filter and overflow flag.
module tx_write_buffer_bloom_forward_unit
   import twbf_pkg::*;
#(
   parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH,
   parameter int ADDR_BITS    = DEFAULT_ADDR_BITS
) (
   input  logic       clock,
   input  logic       reset,
   twbf_req_if.sink   req_chan,
   twbf_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(BUFFER_DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_SELECT,
      S_COMMIT
   } state_type;

   state_type               state_ff;
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           remain_ff;
   logic [FILTER_W-1:0]     filter_ff;
   logic                    ovf_ff;
   logic [ADDR_BITS-1:0]    key_ff;
   logic [DATA_W-1:0]       memv_ff;

   logic                    rsp_valid_ff;
   kind_type                kind_ff;
   logic [FIELD_ADDR_W-1:0] oaddr_ff;
   logic [DATA_W-1:0]       ovalue_ff;
   logic                    fwd_ff;
   logic                    ovfo_ff;
   logic                    last_ff;

   logic [ADDR_BITS-1:0]    cell_addr  [BUFFER_DEPTH];
   logic [DATA_W-1:0]       cell_data  [BUFFER_DEPTH];
   logic [BUFFER_DEPTH-1:0] cell_match;
   cell_ctrl_type           cell_ctrl  [BUFFER_DEPTH];

   logic                    req_fire;
   logic                    out_free;
   logic                    full;
   logic [ADDR_BITS-1:0]    req_addr;
   logic                    filter_hit;
   logic [BUFFER_DEPTH-1:0] valid_match;
   logic [BUFFER_DEPTH-1:0] newest;
   logic [DATA_W-1:0]       pick_data;
   logic                    hit;

   logic                    emit_en;
   kind_type                e_kind;
   logic [FIELD_ADDR_W-1:0] e_addr;
   logic [DATA_W-1:0]       e_value;
   logic                    e_fwd;
   logic                    e_ovf;
   logic                    e_last;

   function automatic logic [FIELD_ADDR_W-1:0] to_field(logic [ADDR_BITS-1:0] a);
      logic [63:0] w;
      w = 64'(a);
      return w[FIELD_ADDR_W-1:0];
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && out_free;
   assign req_fire   = req_chan.valid && req_chan.ready;
   assign full       = (count_ff == CW'(BUFFER_DEPTH));
   assign req_addr   = ADDR_BITS'(req_chan.addr);
   assign filter_hit = filter_ff[filter_index(req_addr[9:0])];

   genvar g;
   generate
      for (g = 0; g < BUFFER_DEPTH; g++) begin : g_cell
         localparam int NB = (g + 1 < BUFFER_DEPTH) ? g + 1 : g;

         assign cell_ctrl[g].shift = (state_ff == S_COMMIT) && out_free;
         assign cell_ctrl[g].write = req_fire && (req_chan.func == FUNC_STORE) && !full
                                     && (count_ff == CW'(g));

         twbf_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
            .clock    (clock),
            .ctrl     (cell_ctrl[g]),
            .wr_addr  (req_addr),
            .wr_data  (req_chan.value),
            .nbr_addr (cell_addr[NB]),
            .nbr_data (cell_data[NB]),
            .key      (key_ff),
            .addr_ff  (cell_addr[g]),
            .data_ff  (cell_data[g]),
            .match_ff (cell_match[g])
         );
      end
   endgenerate

   // The newest live entry with a matching address wins.
   always_comb begin
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
         valid_match[i] = cell_match[i] && (CW'(i) < count_ff);
      end
      pick_data = '0;
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
         newest[i] = valid_match[i] && !(|(valid_match >> (i + 1)));
         pick_data = pick_data | (cell_data[i] & {DATA_W{newest[i]}});
      end
      hit = |valid_match;
   end

   always_comb begin
      emit_en = 1'b0;
      e_kind  = KIND_ACK;
      e_addr  = '0;
      e_value = '0;
      e_fwd   = 1'b0;
      e_ovf   = ovf_ff;
      e_last  = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.func)
                  FUNC_START: begin
                     emit_en = 1'b1;
                     e_ovf   = 1'b0;
                  end
                  FUNC_STORE: begin
                     emit_en = 1'b1;
                     e_addr  = to_field(req_addr);
                     if (full) begin
                        e_kind = KIND_OVERFLOW;
                        e_ovf  = 1'b1;
                     end
                  end
                  FUNC_LOAD: begin
                     if (!filter_hit) begin
                        emit_en = 1'b1;
                        e_kind  = KIND_LOAD;
                        e_addr  = to_field(req_addr);
                        e_value = req_chan.mem_value;
                     end
                  end
                  FUNC_COMMIT: begin
                     if (count_ff == '0) begin
                        emit_en = 1'b1;
                        e_kind  = KIND_EMPTY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MATCH: ;
         S_SELECT: begin
            if (out_free) begin
               emit_en = 1'b1;
               e_kind  = KIND_LOAD;
               e_addr  = to_field(key_ff);
               e_value = hit ? pick_data : memv_ff;
               e_fwd   = hit;
            end
         end
         S_COMMIT: begin
            if (out_free) begin
               emit_en = 1'b1;
               e_kind  = KIND_WRITEBACK;
               e_addr  = to_field(cell_addr[0]);
               e_value = cell_data[0];
               e_last  = (remain_ff == CW'(1));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         filter_ff    <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (emit_en) begin
            rsp_valid_ff <= 1'b1;
            kind_ff      <= e_kind;
            oaddr_ff     <= e_addr;
            ovalue_ff    <= e_value;
            fwd_ff       <= e_fwd;
            ovfo_ff      <= e_ovf;
            last_ff      <= e_last;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  unique case (req_chan.func)
                     FUNC_START: begin
                        count_ff  <= '0;
                        filter_ff <= '0;
                        ovf_ff    <= 1'b0;
                     end
                     FUNC_STORE: begin
                        if (full) begin
                           ovf_ff <= 1'b1;
                        end else begin
                           count_ff  <= count_ff + CW'(1);
                           filter_ff <= filter_ff
                                        | (FILTER_W'(1) << filter_index(req_addr[9:0]));
                        end
                     end
                     FUNC_LOAD: begin
                        key_ff  <= req_addr;
                        memv_ff <= req_chan.mem_value;
                        if (filter_hit) begin
                           state_ff <= S_MATCH;
                        end
                     end
                     FUNC_COMMIT: begin
                        filter_ff <= '0;
                        count_ff  <= '0;
                        remain_ff <= count_ff;
                        if (count_ff == '0) begin
                           ovf_ff <= 1'b0;
                        end else begin
                           state_ff <= S_COMMIT;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_MATCH: begin
               state_ff <= S_SELECT;
            end
            S_SELECT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            S_COMMIT: begin
               if (out_free) begin
                  remain_ff <= remain_ff - CW'(1);
                  // The flag shows on every word of the commit and clears after the last.
                  if (remain_ff == CW'(1)) begin
                     ovf_ff   <= 1'b0;
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = kind_ff;
   assign rsp_chan.out_addr   = oaddr_ff;
   assign rsp_chan.out_value  = ovalue_ff;
   assign rsp_chan.forwarded  = fwd_ff;
   assign rsp_chan.overflowed = ovfo_ff;
   assign rsp_chan.last       = last_ff;

endmodule
